// ----- src/deque_with_indexed_delete_top_assert.svh -----
// Assertion macros used by the deque controller.
`ifndef DEQUE_WITH_INDEXED_DELETE_TOP_ASSERT_SVH
`define DEQUE_WITH_INDEXED_DELETE_TOP_ASSERT_SVH

// Checked on every rising edge outside reset.
`define DWID_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define DWID_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/dwid_pkg.sv -----
// Package: types, codes and widths of the deque with indexed delete.
`timescale 1ns / 1ps
`default_nettype none
package dwid_pkg;

	localparam int DEPTH_DEF    = 32;
	localparam int ACTION_W     = 2;
	localparam int VALUE_W      = 32;
	localparam int POSITION_W   = 5;
	localparam int LENGTH_W     = 6;
	localparam int IN_TDATA_W   = 32;
	localparam int IN_TUSER_W   = 2;
	localparam int OUT_TDATA_W  = 48;
	localparam int OUT_TUSER_W  = 3;

	typedef enum logic [ACTION_W-1:0] {
		ACT_PUSH_FRONT = 2'd0,
		ACT_PUSH_BACK  = 2'd1,
		ACT_DELETE     = 2'd2,
		ACT_NONE       = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FWD,
		ST_BWD
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic apply;     // take the request and update the list
		logic emit;      // load the output register
		logic backward;
		logic last;
		logic inc;
		logic dec;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic empty;
		logic at_end;
		logic at_zero;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

// ----- src/dwid_ctrl.sv -----
// Controller: dump walk fwd then bwd; one result per cycle if output free.
`timescale 1ns / 1ps
`default_nettype none
`include "deque_with_indexed_delete_top_assert.svh"
module dwid_ctrl (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           in_valid,
	output logic          in_ready,
	input  dwid_pkg::sts_t sts,
	output dwid_pkg::cmd_t cmd
);
	import dwid_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_FWD;
			end
			ST_FWD: begin
				if (sts.out_free) begin
					if (sts.empty) state_d = ST_IDLE;
					else if (sts.at_end) state_d = ST_BWD;
				end
			end
			ST_BWD: begin
				if (sts.out_free && sts.at_zero) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.apply = in_valid;
			end
			ST_FWD: begin
				cmd.emit = sts.out_free;
				cmd.last = sts.empty;
				cmd.inc  = sts.out_free && !sts.empty && !sts.at_end;
			end
			ST_BWD: begin
				cmd.emit     = sts.out_free;
				cmd.backward = 1'b1;
				cmd.last     = sts.at_zero;
				cmd.dec      = sts.out_free && !sts.at_zero;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	`DWID_ASSERT(a_apply_starts_dump, cmd.apply |=> (state_q == ST_FWD), "request did not start a dump")
	`DWID_ASSERT(a_emit_needs_room, cmd.emit |-> sts.out_free, "result emitted into a full output register")
	`DWID_ASSERT(a_idle_after_last, (cmd.emit && cmd.last) |=> (state_q == ST_IDLE), "dump did not end after last result")
	`DWID_ASSERT_ALWAYS(a_no_move_idle, (state_q == ST_IDLE) |-> !(cmd.inc || cmd.dec || cmd.emit), "walk moved while idle")

endmodule
`default_nettype wire

// ----- src/dwid_dp.sv -----
// Datapath: list register file with parallel shift, walk pointer, output register.
`timescale 1ns / 1ps
`default_nettype none
module dwid_dp #(
	parameter int DEPTH = dwid_pkg::DEPTH_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire  [dwid_pkg::ACTION_W-1:0]   action,
	input  wire  [dwid_pkg::VALUE_W-1:0]    operand,
	input  dwid_pkg::cmd_t                  cmd,
	output dwid_pkg::sts_t                  sts,
	input  wire                             out_ready,
	output logic                            out_valid,
	output logic                            out_backward,
	output logic [dwid_pkg::POSITION_W-1:0] out_position,
	output logic [dwid_pkg::VALUE_W-1:0]    out_value,
	output logic [dwid_pkg::LENGTH_W-1:0]   out_length,
	output logic                            out_empty,
	output logic                            out_dropped,
	output logic                            out_last
);
	import dwid_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [VALUE_W-1:0] entries_q [DEPTH];
	logic [CW-1:0]      count_q;
	logic               drop_q;
	logic [IW-1:0]      pos_q;

	logic          full;
	logic          do_front;
	logic          do_back;
	logic          do_del;
	logic [IW-1:0] del_idx;
	logic [IW-1:0] tail_idx;

	assign full     = (count_q == CW'(DEPTH));
	assign del_idx  = operand[IW-1:0];
	assign tail_idx = count_q[IW-1:0];
	assign do_front = cmd.apply && (action == ACT_PUSH_FRONT) && !full;
	assign do_back  = cmd.apply && (action == ACT_PUSH_BACK) && !full;
	// Negative or out-of-range index: ignore.
	assign do_del   = cmd.apply && (action == ACT_DELETE) && !operand[VALUE_W-1]
		&& (operand[VALUE_W-2:0] < (VALUE_W-1)'(count_q));

	for (genvar i = 0; i < DEPTH; i++) begin : g_entry
		logic [VALUE_W-1:0] lower;
		logic [VALUE_W-1:0] upper;
		if (i > 0) begin : g_lo
			assign lower = entries_q[i-1];
		end else begin : g_lo0
			assign lower = operand;
		end
		if (i < DEPTH - 1) begin : g_up
			assign upper = entries_q[i+1];
		end else begin : g_upn
			assign upper = entries_q[i];
		end

		always_ff @(posedge clk) begin
			if (do_front) begin
				entries_q[i] <= lower;
			end else if (do_back && (tail_idx == IW'(i))) begin
				entries_q[i] <= operand;
			end else if (do_del && (IW'(i) >= del_idx)) begin
				entries_q[i] <= upper;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			drop_q  <= 1'b0;
			pos_q   <= '0;
		end else begin
			if (do_front || do_back) begin
				count_q <= count_q + CW'(1);
			end else if (do_del) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.apply) begin
				drop_q <= full && ((action == ACT_PUSH_FRONT) || (action == ACT_PUSH_BACK));
				pos_q  <= '0;
			end else if (cmd.inc) begin
				pos_q <= pos_q + IW'(1);
			end else if (cmd.dec) begin
				pos_q <= pos_q - IW'(1);
			end
		end
	end

	// Output register: hold until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_backward <= cmd.backward;
			out_position <= POSITION_W'(pos_q);
			out_value    <= sts.empty ? '0 : entries_q[pos_q];
			out_length   <= LENGTH_W'(count_q);
			out_empty    <= sts.empty;
			out_dropped  <= drop_q;
			out_last     <= cmd.last;
		end
	end

	assign sts.empty    = (count_q == '0);
	assign sts.at_end   = (CW'(pos_q) == (count_q - CW'(1)));
	assign sts.at_zero  = (pos_q == '0);
	assign sts.out_free = !out_valid || out_ready;

endmodule
`default_nettype wire

// ----- src/deque_with_indexed_delete_top.sv -----
// Top level: deque with indexed delete and full dump after each request.
//
//  channel  | dir | tdata                          | tuser                          | tlast
//  s_axis   | in  | [31:0] operand                 | [1:0] action                   | -
//  m_axis   | out | [4:0] position, [36:5] value,  | [0] backward, [1] is_empty,    | last
//           |     | [42:37] length, [47:43] zero   | [2] dropped                    |
//
// A request is taken in the idle state, then its dump streams at one result per cycle
// while m_axis has room: 2*length results, or a single one for an empty list; the next
// request is taken only after the dump's last result has entered the output register.
// The walk reads one entry a cycle, unless the output is held, through the register file's single read mux.
// Reset clears the entry count; the stored values are not cleared.
// m_axis_tready low holds the walk; the last result may wait while the next request enters.
`timescale 1ns / 1ps
`default_nettype none
module deque_with_indexed_delete_top #(
	parameter int DEPTH = dwid_pkg::DEPTH_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_axis_tvalid,
	output logic                              s_axis_tready,
	input  wire  [dwid_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // operand
	input  wire  [dwid_pkg::IN_TUSER_W-1:0]   s_axis_tuser,   // action
	output logic                              m_axis_tvalid,
	input  wire                               m_axis_tready,
	output logic [dwid_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,   // position, entry_value, length
	output logic [dwid_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,   // backward, is_empty, dropped
	output logic                              m_axis_tlast
);
	import dwid_pkg::*;

	cmd_t                  cmd;
	sts_t                  sts;
	logic                  out_backward;
	logic [POSITION_W-1:0] out_position;
	logic [VALUE_W-1:0]    out_value;
	logic [LENGTH_W-1:0]   out_length;
	logic                  out_empty;
	logic                  out_dropped;

	dwid_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dwid_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.action       (s_axis_tuser),
		.operand      (s_axis_tdata),
		.cmd          (cmd),
		.sts          (sts),
		.out_ready    (m_axis_tready),
		.out_valid    (m_axis_tvalid),
		.out_backward (out_backward),
		.out_position (out_position),
		.out_value    (out_value),
		.out_length   (out_length),
		.out_empty    (out_empty),
		.out_dropped  (out_dropped),
		.out_last     (m_axis_tlast)
	);

	assign m_axis_tdata = {
		(OUT_TDATA_W - LENGTH_W - VALUE_W - POSITION_W)'(0),
		out_length, out_value, out_position
	};
	assign m_axis_tuser = {out_dropped, out_empty, out_backward};

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Testbench for the deque with indexed delete: drives list requests and checks each dump entry.
module testbench;
	import dwid_pkg::*;

	localparam int DEPTH = DEPTH_DEF;
	localparam int HALF_PERIOD = 2;
	localparam int RESET_CYCLES = 11;
	localparam int SETTLE_CYCLES = 2 * DEPTH + 16;
	localparam int EXP_DEPTH = 256;

	typedef struct packed {
		logic                  backward;
		logic [POSITION_W-1:0] position;
		logic [VALUE_W-1:0]    entry_value;
		logic [LENGTH_W-1:0]   length;
		logic                  is_empty;
		logic                  dropped;
		logic                  last;
	} dump_entry_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	wire                    s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // operand
	logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;   // action
	wire                    m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	wire  [OUT_TDATA_W-1:0] m_axis_tdata;        // position, entry_value, length, zero pad
	wire  [OUT_TUSER_W-1:0] m_axis_tuser;        // backward, is_empty, dropped
	wire                    m_axis_tlast;

	// Shadow copy of the list, front at index 0.
	logic [VALUE_W-1:0] shadow_list [DEPTH];
	int unsigned        shadow_len = 0;
	// Expected results, kept in a ring indexed by free-running counters.
	dump_entry_t        exp_buf [EXP_DEPTH];
	int unsigned        exp_wr = 0;
	int unsigned        exp_rd = 0;
	int unsigned        error_count = 0;
	bit                 tx_eager = 1'b0;
	bit                 rx_eager = 1'b0;

	deque_with_indexed_delete_top #(
		.DEPTH(DEPTH)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always #(HALF_PERIOD) clk = ~clk;

	function automatic void queue_entry(logic bwd, int unsigned pos, logic empty, logic drop,
			logic fin);
		dump_entry_t e;
		e.backward = bwd;
		e.position = pos[POSITION_W-1:0];
		e.entry_value = empty ? '0 : shadow_list[pos];
		e.length = shadow_len[LENGTH_W-1:0];
		e.is_empty = empty;
		e.dropped = drop;
		e.last = fin;
		exp_buf[exp_wr % EXP_DEPTH] = e;
		exp_wr++;
	endfunction

	// Apply one request to the shadow list and queue its full dump.
	function automatic void predict_dump(action_t act, logic [VALUE_W-1:0] opnd);
		logic        drop;
		int unsigned idx;
		drop = 1'b0;
		case (act)
			ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
				if (shadow_len >= DEPTH) begin
					drop = 1'b1;
				end else if (act == ACT_PUSH_FRONT) begin
					for (idx = shadow_len; idx > 0; idx--)
						shadow_list[idx] = shadow_list[idx-1];
					shadow_list[0] = opnd;
					shadow_len++;
				end else begin
					shadow_list[shadow_len] = opnd;
					shadow_len++;
				end
			end
			ACT_DELETE: begin
				// negative or out-of-range index leaves the list alone
				if (!opnd[VALUE_W-1] && opnd < shadow_len) begin
					for (idx = opnd; idx + 1 < shadow_len; idx++)
						shadow_list[idx] = shadow_list[idx+1];
					shadow_len--;
				end
			end
			default: ;
		endcase
		if (shadow_len == 0) begin
			queue_entry(1'b0, 0, 1'b1, drop, 1'b1);
		end else begin
			for (idx = 0; idx < shadow_len; idx++)
				queue_entry(1'b0, idx, 1'b0, drop, 1'b0);
			for (idx = shadow_len; idx > 0; idx--)
				queue_entry(1'b1, idx - 1, 1'b0, drop, idx == 1);
		end
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			error_count++;
		end
	endfunction

	function automatic void check_result();
		dump_entry_t want;
		dump_entry_t got;
		got.position = m_axis_tdata[4:0];
		got.entry_value = m_axis_tdata[36:5];
		got.length = m_axis_tdata[42:37];
		got.backward = m_axis_tuser[0];
		got.is_empty = m_axis_tuser[1];
		got.dropped = m_axis_tuser[2];
		got.last = m_axis_tlast;
		if (exp_wr == exp_rd) begin
			$display("%0t: unexpected result, expected none, actual %0h", $time, got);
			error_count++;
		end else begin
			want = exp_buf[exp_rd % EXP_DEPTH];
			exp_rd++;
			check_field("backward", want.backward, got.backward);
			check_field("position", want.position, got.position);
			check_field("entry_value", want.entry_value, got.entry_value);
			check_field("length", want.length, got.length);
			check_field("is_empty", want.is_empty, got.is_empty);
			check_field("dropped", want.dropped, got.dropped);
			check_field("last", want.last, got.last);
		end
	endfunction

	// Result side: random stall before each result (none when rx_eager), then take it and check.
	initial begin : result_sink
		int unsigned stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = rx_eager ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
			check_result();
		end
	end

	// Call at a rising edge; returns at the edge the request is taken.
	task automatic send_request(action_t act, logic [VALUE_W-1:0] opnd);
		int unsigned gap;
		gap = tx_eager ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= opnd;
		s_axis_tuser <= act;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_dump(act, opnd);
	endtask

	task automatic pause_until_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (exp_wr != exp_rd) @(posedge clk);
	endtask

	function automatic logic [VALUE_W-1:0] draw_value();
		case ($urandom_range(0, 19))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [VALUE_W-1:0] draw_index();
		if (shadow_len > 0 && $urandom_range(0, 99) < 75)
			return $urandom_range(0, shadow_len - 1);
		case ($urandom_range(0, 3))
			0: return shadow_len;
			1: return $urandom;
			2: return shadow_len + $urandom_range(1, 40);
			default: return {1'b1, 31'($urandom)};
		endcase
	endfunction

	task automatic test_empty_list();
		send_request(ACT_NONE, $urandom);
		send_request(ACT_DELETE, 32'd0);
		send_request(ACT_DELETE, 32'hFFFF_FFFF);
		send_request(ACT_DELETE, 32'h8000_0000);
	endtask

	task automatic test_push_extremes();
		send_request(ACT_PUSH_FRONT, 32'h7FFF_FFFF);
		send_request(ACT_PUSH_BACK, 32'h8000_0000);
		send_request(ACT_PUSH_FRONT, 32'h0000_0000);
		send_request(ACT_PUSH_BACK, 32'hFFFF_FFFF);
		send_request(ACT_PUSH_BACK, 32'h0000_0001);
		send_request(ACT_NONE, $urandom);
	endtask

	task automatic test_delete_cases();
		send_request(ACT_DELETE, 32'd5);
		send_request(ACT_DELETE, 32'h7FFF_FFFF);
		send_request(ACT_DELETE, 32'h8000_0000);
		send_request(ACT_DELETE, 32'd0);
		send_request(ACT_DELETE, 32'd3);
		send_request(ACT_DELETE, 32'd1);
		send_request(ACT_DELETE, 32'd0);
		send_request(ACT_DELETE, 32'd0);
	endtask

	task automatic test_full_list();
		tx_eager = 1'b1;
		rx_eager = 1'b1;
		while (shadow_len < DEPTH)
			send_request($urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT, draw_value());
		tx_eager = 1'b0;
		rx_eager = 1'b0;
		send_request(ACT_PUSH_FRONT, $urandom);
		send_request(ACT_PUSH_BACK, $urandom);
		send_request(ACT_DELETE, DEPTH);
		send_request(ACT_DELETE, DEPTH - 1);
		send_request(ACT_PUSH_FRONT, $urandom);
		send_request(ACT_PUSH_BACK, $urandom);
		send_request(ACT_NONE, $urandom);
	endtask

	// Phases of 40 requests: grow, shrink, then two balanced; eager modes are redrawn at random per phase.
	task automatic test_random_traffic(int unsigned count);
		int unsigned n;
		int unsigned roll;
		int unsigned push_pct;
		int unsigned del_pct;
		for (n = 0; n < count; n++) begin
			if (n % 40 == 0) begin
				tx_eager = ($urandom_range(0, 3) == 0);
				rx_eager = ($urandom_range(0, 3) == 0);
			end
			case ((n / 40) % 4)
				0: begin
					push_pct = 70;
					del_pct = 20;
				end
				1: begin
					push_pct = 20;
					del_pct = 70;
				end
				default: begin
					push_pct = 45;
					del_pct = 45;
				end
			endcase
			roll = $urandom_range(0, 99);
			if (roll < push_pct)
				send_request($urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT,
					draw_value());
			else if (roll < push_pct + del_pct)
				send_request(ACT_DELETE, draw_index());
			else
				send_request(ACT_NONE, $urandom);
		end
		tx_eager = 1'b0;
		rx_eager = 1'b0;
	endtask

	task automatic finish_run();
		pause_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0 && exp_wr == exp_rd)
			$display("[deque_with_indexed_delete_top] OK");
		else
			$display("[deque_with_indexed_delete_top] ERROR");
		$finish;
	endtask

	initial begin : stimulus
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		test_push_extremes();
		test_delete_cases();
		pause_until_drained();
		test_full_list();
		pause_until_drained();
		test_random_traffic(260);
		finish_run();
	end

	initial begin : watchdog
		#8_000_000;
		$display("[deque_with_indexed_delete_top] ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+src
src/dwid_pkg.sv
src/dwid_ctrl.sv
src/dwid_dp.sv
src/deque_with_indexed_delete_top.sv
bench/testbench.sv
